// ----- hdl/gemm_u8_bias_sat_u16_macros.svh -----
// assertion macros for the gemm block
`ifndef GEMM_U8_BIAS_SAT_U16_MACROS_SVH
`define GEMM_U8_BIAS_SAT_U16_MACROS_SVH
// assert an implication in the same cycle
`define GEMM_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert an implication in the next cycle
`define GEMM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- hdl/gemm_pkg.sv -----
// shared types and constants of the gemm block
package gemm_pkg;
    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_BIAS   = 2'd1;
    localparam logic [1:0] KIND_ACT    = 2'd2;
    localparam logic [1:0] REG_K_LEN     = 2'd0;
    localparam logic [1:0] REG_N_LEN     = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT = 2'd2;
    localparam int ACC_W = 42;
    typedef struct packed {
        logic clear;
        logic en;
    } gemm_cell_ctl_t;
endpackage

// ----- hdl/gemm_cell.sv -----
// one multiply-accumulate cell that owns one column
module gemm_cell
(
    input  logic                       clk,
    input  gemm_pkg::gemm_cell_ctl_t   ctl,
    input  logic [7:0]                 act_in,
    input  logic [7:0]                 weight,
    input  logic signed [31:0]         bias,
    output logic signed [gemm_pkg::ACC_W-1:0] acc
);
    logic signed [gemm_pkg::ACC_W-1:0] acc_reg;
    logic signed [gemm_pkg::ACC_W-1:0] acc_next;
    logic signed [gemm_pkg::ACC_W-1:0] base;
    logic [15:0] prod;

    always_comb
    begin
        prod = 16'(act_in) * 16'(weight);
        base = ctl.clear ? gemm_pkg::ACC_W'(bias) : acc_reg;
        acc_next = base + gemm_pkg::ACC_W'(signed'({1'b0, prod}));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;
endmodule

// ----- hdl/gemm_u8_bias_sat_u16.sv -----
// top level: stores, column cells and result sequencer
// a beat that only fills a store is accepted without holding the input
// after the row-final activation beat, in_stall stays high while the activation
// row streams through the cells and the results load into the output register
// one per beat, and also through any output stall cycles
// reset is asynchronous active low on control and output registers; no store clearing
module gemm_u8_bias_sat_u16
#(
    parameter int MAX_K = 256,
    parameter int MAX_N = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [7:0]         k_index,
    input  logic [5:0]         n_index,
    input  logic [7:0]         byte_value,
    input  logic signed [31:0] bias_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        out_value,
    output logic [5:0]         out_column,
    output logic               row_last,
    output logic               matrix_last,
    output logic               clipped,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    `include "gemm_u8_bias_sat_u16_macros.svh"

    localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW = $clog2(MAX_K + 1);
    localparam int NCW = $clog2(MAX_N + 1);
    localparam int NW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int AW = gemm_pkg::ACC_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [8:0]  k_len_reg;
    logic [6:0]  n_len_reg;
    logic [15:0] row_count_reg;
    logic [15:0] row_counter_reg;
    logic [1:0]  state_reg;
    logic [KCW-1:0] k_cnt_reg;
    logic [KCW-1:0] k_rd_reg;
    logic        rd_vld_reg;
    logic [NCW-1:0] n_cnt_reg;
    logic        last_row_reg;
    logic        first_reg;

    logic [8*MAX_N-1:0] weight_row_mem [MAX_K];
    logic [7:0]  act_mem [MAX_K];
    logic signed [31:0] bias_mem [MAX_N];
    logic [8*MAX_N-1:0] wrow_reg;
    logic [7:0]  act_rd_reg;

    logic [KCW-1:0] eff_k;
    logic [NCW-1:0] eff_n;
    logic [15:0] eff_rows;
    logic        in_acc;
    logic        fire;
    logic        load_out;
    logic        ovalid_reg;
    logic [15:0] oval_reg;
    logic [5:0]  ocol_reg;
    logic        orow_reg;
    logic        omat_reg;
    logic        oclip_reg;

    logic signed [AW-1:0] accs [MAX_N];
    gemm_pkg::gemm_cell_ctl_t ctl;

    assign eff_k = (k_len_reg == 9'd0) ? KCW'(1)
                 : ({{(32-9){1'b0}}, k_len_reg} > 32'(MAX_K)) ? KCW'(MAX_K)
                 : KCW'(k_len_reg);
    assign eff_n = (n_len_reg == 7'd0) ? NCW'(1)
                 : ({{(32-7){1'b0}}, n_len_reg} > 32'(MAX_N)) ? NCW'(MAX_N)
                 : NCW'(n_len_reg);
    assign eff_rows = (row_count_reg == 16'd0) ? 16'd1 : row_count_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign fire = in_acc && kind == gemm_pkg::KIND_ACT && 32'(k_index) < 32'(MAX_K)
                  && {{(32-8){1'b0}}, k_index} == 32'(eff_k) - 32'd1;
    assign load_out = (state_reg == ST_OUT) && (!ovalid_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        if (in_acc && kind == gemm_pkg::KIND_WEIGHT && 32'(k_index) < 32'(MAX_K)
            && 32'(n_index) < 32'(MAX_N))
        begin
            weight_row_mem[KW'(k_index)][8*NW'(n_index) +: 8] <= byte_value;
        end
        if (in_acc && kind == gemm_pkg::KIND_BIAS && 32'(n_index) < 32'(MAX_N))
        begin
            bias_mem[NW'(n_index)] <= bias_value;
        end
        if (in_acc && kind == gemm_pkg::KIND_ACT && 32'(k_index) < 32'(MAX_K))
        begin
            act_mem[KW'(k_index)] <= byte_value;
        end
        wrow_reg <= weight_row_mem[KW'(k_rd_reg)];
        act_rd_reg <= act_mem[KW'(k_rd_reg)];
    end

    // activation and weight row of one k reach every column cell together
    assign ctl.en = rd_vld_reg;
    assign ctl.clear = first_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_N; g++)
        begin : g_cell
            gemm_cell u_cell
            (
                .clk     (clk),
                .ctl     (ctl),
                .act_in  (act_rd_reg),
                .weight  (wrow_reg[8*g +: 8]),
                .bias    (bias_mem[g]),
                .acc     (accs[g])
            );
        end
    endgenerate

    logic signed [AW-1:0] sel_acc;
    assign sel_acc = accs[NW'(n_cnt_reg)];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_len_reg <= 9'd256;
            n_len_reg <= 7'd64;
            row_count_reg <= 16'd1;
            row_counter_reg <= 16'd0;
            state_reg <= ST_IDLE;
            k_cnt_reg <= '0;
            k_rd_reg <= '0;
            rd_vld_reg <= 1'b0;
            first_reg <= 1'b0;
            n_cnt_reg <= '0;
            last_row_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            oval_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= 1'b0;
            omat_reg <= 1'b0;
            oclip_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gemm_pkg::REG_K_LEN:     k_len_reg <= cfg_data[8:0];
                    gemm_pkg::REG_N_LEN:     n_len_reg <= cfg_data[6:0];
                    gemm_pkg::REG_ROW_COUNT: row_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    rd_vld_reg <= 1'b0;
                    if (fire)
                    begin
                        last_row_reg <= (32'(row_counter_reg) + 32'd1 >= 32'(eff_rows));
                        row_counter_reg <= (32'(row_counter_reg) + 32'd1 >= 32'(eff_rows))
                                         ? 16'd0 : row_counter_reg + 16'd1;
                        k_rd_reg <= '0;
                        k_cnt_reg <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    // read issued at k_rd; data valid in the next cycle
                    first_reg <= (k_rd_reg == '0);
                    if (k_cnt_reg == eff_k)
                    begin
                        rd_vld_reg <= 1'b0;
                        n_cnt_reg <= '0;
                        state_reg <= ST_OUT;
                    end
                    else if (k_rd_reg != eff_k)
                    begin
                        k_rd_reg <= k_rd_reg + KCW'(1);
                        rd_vld_reg <= 1'b1;
                        if (rd_vld_reg)
                        begin
                            k_cnt_reg <= k_cnt_reg + KCW'(1);
                        end
                    end
                    else
                    begin
                        rd_vld_reg <= (k_cnt_reg + KCW'(1) != eff_k);
                        k_cnt_reg <= k_cnt_reg + KCW'(1);
                    end
                end
                ST_OUT:
                begin
                    rd_vld_reg <= 1'b0;
                    if (load_out)
                    begin
                        oval_reg <= (sel_acc < 0) ? 16'd0
                                  : (sel_acc > AW'(65535)) ? 16'hFFFF : sel_acc[15:0];
                        oclip_reg <= (sel_acc < 0) || (sel_acc > AW'(65535));
                        ocol_reg <= 6'(n_cnt_reg);
                        orow_reg <= (n_cnt_reg == eff_n - NCW'(1));
                        omat_reg <= (n_cnt_reg == eff_n - NCW'(1)) && last_row_reg;
                        n_cnt_reg <= n_cnt_reg + NCW'(1);
                        if (n_cnt_reg == eff_n - NCW'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = ovalid_reg;
    assign out_value = oval_reg;
    assign out_column = ocol_reg;
    assign row_last = orow_reg;
    assign matrix_last = omat_reg;
    assign clipped = oclip_reg;

    `GEMM_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `GEMM_ASSERT_IMP(a_mat_row, clk, rst_n, out_valid && matrix_last, row_last)
    `GEMM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value))
endmodule
